[src/srb_pkg.sv]
// Shared types and constants for the sequence reorder buffer.
package srb_pkg;

	localparam int unsigned WINDOW_DEF   = 32;
	localparam int unsigned HEADER_BYTES = 12;

	localparam int unsigned IN_W   = 64;
	localparam int unsigned OUT_W  = 232;
	localparam int unsigned PAY_W  = 16;
	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned BYTE_W = 48;

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	typedef enum logic [2:0] {
		STAT_IN_ORDER  = 3'd0,
		STAT_REORDERED = 3'd1,
		STAT_SHORT     = 3'd2,
		STAT_STALE     = 3'd3,
		STAT_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_READ,
		S_DELIVER
	} state_t;

	// one counter update, applied on a result transfer into the output register
	typedef struct packed {
		logic              rx;
		logic              drop;
		logic              reord;
		logic              deliv;
		logic [PAY_W-1:0]  bytes;
	} stat_upd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  received;
		logic [CNT_W-1:0]  delivered;
		logic [CNT_W-1:0]  dropped;
		logic [CNT_W-1:0]  reordered;
		logic [BYTE_W-1:0] bytes;
	} stat_cnt_t;

endpackage

[src/sequence_reorder_buffer.sv]
// Sequence reorder buffer top level: arrival classification and in-order release.
//
// Usage:
//   Slave side takes one packet header per transfer: tdata holds packet_length,
//   sequence_req and payload_size. Each arrival produces a status report
//   (m_tuser = 0) followed by zero or more in-order deliveries (m_tuser = 1).
//   m_tlast marks the final result of the arrival. Every result carries the
//   running counters as they stand after that result.
//   Steps: the header is taken, then classified once the output register is
//   free, while the slot memory is written and the report loads into it. If
//   the arrival fills the expected sequence, the head slot is read, then
//   deliveries follow at one per cycle unless the receiver stalls; the slot
//   memory's single read port sets the one-delivery-per-cycle pace.
//   s_tready is high only between arrivals; a new header is taken while the
//   last result still waits in the output register.
//   Reset clears the expected sequence, all slot valid bits and the counters;
//   the payload memory needs no clearing.
//   When the receiver stalls, the output register holds its result and the
//   sequencer waits; nothing is dropped.
module sequence_reorder_buffer #(
	parameter int unsigned WINDOW = srb_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [15:0] packet_length, [47:16] sequence_req, [63:48] payload_size
	input  logic [srb_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [2:0] status, [34:3] out_sequence, [50:35] out_payload,
	// [82:51] received_count, [114:83] delivered_count, [146:115] dropped_count,
	// [178:147] reordered_count, [226:179] delivered_bytes, [231:227] zero
	output logic [srb_pkg::OUT_W-1:0]   m_tdata,
	// [0] kind
	output logic                        m_tuser,
	output logic                        m_tlast
);
	import srb_pkg::*;

	localparam int unsigned IW = $clog2(WINDOW);
	localparam logic [IW:0] WIN_EXT = (IW+1)'(WINDOW);

	state_t state_q, state_nx;

	// captured arrival
	logic [15:0]      len_q;
	logic [SEQ_W-1:0] seq_q;
	logic [PAY_W-1:0] pay_q;

	// window state
	logic [SEQ_W-1:0]  ne_q;
	logic [IW-1:0]     head_q;
	logic [WINDOW-1:0] valid_q;

	// output register
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tuser_q;
	logic             m_tlast_q;

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// classification of the captured arrival
	logic             is_short, is_stale, is_over, fits, in_place;
	logic [SEQ_W-1:0] seq_gap;
	logic [IW:0]      idx_sum;
	logic [IW-1:0]    idx;
	logic [IW-1:0]    head_nx;
	logic             more;

	always_comb begin
		is_short = len_q < 16'(HEADER_BYTES);
		is_stale = seq_q < ne_q;
		seq_gap  = seq_q - ne_q;
		is_over  = seq_gap >= SEQ_W'(WINDOW);
		fits     = !is_short && !is_stale && !is_over;
		in_place = seq_gap == '0;
		// circular slot index: head + distance, both below WINDOW
		idx_sum  = {1'b0, head_q} + {1'b0, seq_gap[IW-1:0]};
		idx      = (idx_sum >= WIN_EXT) ? IW'(idx_sum - WIN_EXT) : idx_sum[IW-1:0];
		head_nx  = (head_q == IW'(WINDOW - 1)) ? '0 : IW'(head_q + 1'b1);
		more     = valid_q[head_nx];
	end

	// sequencer and datapath controls
	logic             emit, emit_kind, emit_last;
	status_t          emit_status;
	logic [SEQ_W-1:0] emit_seq;
	logic [PAY_W-1:0] emit_pay;
	stat_upd_t        upd;
	stat_cnt_t        cnt_next;
	logic             wr_en, rd_en;
	logic [IW-1:0]    rd_addr;
	logic [PAY_W-1:0] rd_data;

	always_comb begin
		state_nx    = state_q;
		emit        = 1'b0;
		emit_kind   = KIND_STATUS;
		emit_status = STAT_IN_ORDER;
		emit_seq    = seq_q;
		emit_pay    = '0;
		emit_last   = 1'b1;
		upd         = '0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		s_tready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nx = S_EVAL;
				end
			end
			S_EVAL: begin
				if (out_free) begin
					emit     = 1'b1;
					upd.rx   = 1'b1;
					upd.drop = !fits;
					if (is_short) begin
						emit_status = STAT_SHORT;
						emit_seq    = '0;
					end else if (is_stale) begin
						emit_status = STAT_STALE;
					end else if (is_over) begin
						emit_status = STAT_OVERFLOW;
					end else if (!in_place) begin
						emit_status = STAT_REORDERED;
					end
					upd.reord = fits && !in_place;
					// duplicates keep the first payload
					wr_en     = fits && !valid_q[idx];
					// head slot is empty between arrivals, so only an
					// in-place arrival starts a release run
					emit_last = !(fits && in_place);
					state_nx  = (fits && in_place) ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				rd_en    = 1'b1;
				state_nx = S_DELIVER;
			end
			S_DELIVER: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = KIND_DELIVER;
					emit_seq  = ne_q;
					emit_pay  = rd_data;
					emit_last = !more;
					upd.deliv = 1'b1;
					upd.bytes = rd_data;
					rd_en     = more;
					rd_addr   = head_nx;
					state_nx  = more ? S_DELIVER : S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	srb_slot_ram #(
		.WINDOW (WINDOW)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx),
		.wr_data (pay_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	srb_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (emit),
		.upd      (upd),
		.cnt_next (cnt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// arrival capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			len_q <= s_tdata[15:0];
			seq_q <= s_tdata[47:16];
			pay_q <= s_tdata[63:48];
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q    <= '0;
			head_q  <= '0;
			valid_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[idx] <= 1'b1;
			end
			if (emit && state_q == S_DELIVER) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_nx;
				ne_q            <= ne_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {5'b0, cnt_next.bytes, cnt_next.reordered, cnt_next.dropped,
				cnt_next.delivered, cnt_next.received, emit_pay, emit_seq, emit_status};
			m_tuser_q <= emit_kind;
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// between arrivals the slot at the head of the window is always empty
	a_head_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !valid_q[head_q])
		else $error("head slot valid while idle");

	// slot memory never written and read in the same cycle
	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("slot memory write and read overlap");

	// expected sequence advances only on a delivery
	a_ne_on_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		ne_q != $past(ne_q) |-> $past(state_q) == S_DELIVER)
		else $error("expected sequence moved outside delivery");

	// deliveries are preceded by a head read
	a_deliver_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DELIVER |-> $past(state_q) == S_READ || $past(state_q) == S_DELIVER)
		else $error("delivery without head read");

endmodule

[src/srb_slot_ram.sv]
// Payload slot memory: one write port, one registered read port.
module srb_slot_ram #(
	parameter int unsigned WINDOW = srb_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(WINDOW)-1:0]         wr_addr,
	input  logic [srb_pkg::PAY_W-1:0]         wr_data,
	input  logic                              rd_en,
	input  logic [$clog2(WINDOW)-1:0]         rd_addr,
	output logic [srb_pkg::PAY_W-1:0]         rd_data
);
	import srb_pkg::*;

	logic [PAY_W-1:0] mem [WINDOW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/srb_stats.sv]
// Running packet and byte counters.
module srb_stats (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  srb_pkg::stat_upd_t    upd,
	output srb_pkg::stat_cnt_t    cnt_next
);
	import srb_pkg::*;

	stat_cnt_t cnt_q;

	always_comb begin
		cnt_next.received  = cnt_q.received  + CNT_W'(upd.rx);
		cnt_next.delivered = cnt_q.delivered + CNT_W'(upd.deliv);
		cnt_next.dropped   = cnt_q.dropped   + CNT_W'(upd.drop);
		cnt_next.reordered = cnt_q.reordered + CNT_W'(upd.reord);
		cnt_next.bytes     = cnt_q.bytes     + BYTE_W'(upd.bytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

[tb/tb_sequence_reorder_buffer.sv]
// Self-checking testbench for the sequence reorder buffer: stream stimulus, predictor, checker.
`timescale 1ns / 100ps

module tb_sequence_reorder_buffer;
	import srb_pkg::*;

	// Predicts the report and in-order releases for each arrival and checks results in order.
	class reorder_tracker;
		typedef struct {
			logic              kind;
			status_t           status;
			logic [SEQ_W-1:0]  seq;
			logic [PAY_W-1:0]  pay;
			logic              last;
			stat_cnt_t         cnt;
		} result_t;

		logic [SEQ_W-1:0]  next_seq;
		bit                parked [WINDOW_DEF];
		logic [PAY_W-1:0]  parked_pay [WINDOW_DEF];
		int unsigned       head;
		stat_cnt_t         cnt;
		result_t           pending_results [$];
		int                errors;

		function new();
			next_seq = '0;
			head     = 0;
			cnt      = '0;
			errors   = 0;
			foreach (parked[i]) parked[i] = 1'b0;
		endfunction

		function void push_result(logic kind, status_t st, logic [SEQ_W-1:0] seq,
				logic [PAY_W-1:0] pay);
			result_t r;
			r.kind   = kind;
			r.status = st;
			r.seq    = seq;
			r.pay    = pay;
			r.last   = 1'b0;
			r.cnt    = cnt;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void note_arrival(logic [IN_W-1:0] data);
			logic [15:0]       len;
			logic [SEQ_W-1:0]  seq;
			logic [PAY_W-1:0]  pay;
			logic [SEQ_W-1:0]  seq_gap;
			int unsigned       idx;
			len = data[15:0];
			seq = data[47:16];
			pay = data[63:48];
			cnt.received = cnt.received + 1'b1;
			if (len < HEADER_BYTES) begin
				// header never read, so the sequence reports as zero
				cnt.dropped = cnt.dropped + 1'b1;
				push_result(KIND_STATUS, STAT_SHORT, '0, '0);
			end else if (seq < next_seq) begin
				cnt.dropped = cnt.dropped + 1'b1;
				push_result(KIND_STATUS, STAT_STALE, seq, '0);
			end else begin
				seq_gap = seq - next_seq;
				if (seq_gap >= WINDOW_DEF) begin
					cnt.dropped = cnt.dropped + 1'b1;
					push_result(KIND_STATUS, STAT_OVERFLOW, seq, '0);
				end else begin
					if (seq_gap != 0) cnt.reordered = cnt.reordered + 1'b1;
					idx = (head + seq_gap) % WINDOW_DEF;
					// a duplicate keeps the payload parked first
					if (!parked[idx]) begin
						parked[idx]     = 1'b1;
						parked_pay[idx] = pay;
					end
					push_result(KIND_STATUS, (seq_gap != 0) ? STAT_REORDERED : STAT_IN_ORDER,
						seq, '0);
					while (parked[head]) begin
						parked[head]  = 1'b0;
						cnt.bytes     = cnt.bytes + parked_pay[head];
						cnt.delivered = cnt.delivered + 1'b1;
						push_result(KIND_DELIVER, STAT_IN_ORDER, next_seq, parked_pay[head]);
						next_seq = next_seq + 1'b1;
						head     = (head + 1) % WINDOW_DEF;
					end
				end
			end
			pending_results[pending_results.size() - 1].last = 1'b1;
		endfunction

		function void compare(string what, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic kind, logic [OUT_W-1:0] data, logic last);
			result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind %0d data %h",
					$time, kind, data);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare("kind", e.kind, kind);
			compare("status", e.status, data[2:0]);
			compare("out_sequence", e.seq, data[34:3]);
			compare("out_payload", e.pay, data[50:35]);
			compare("last", e.last, last);
			compare("received_count", e.cnt.received, data[82:51]);
			compare("delivered_count", e.cnt.delivered, data[114:83]);
			compare("dropped_count", e.cnt.dropped, data[146:115]);
			compare("reordered_count", e.cnt.reordered, data[178:147]);
			compare("delivered_bytes", e.cnt.bytes, data[226:179]);
			compare("pad bits", '0, data[231:227]);
		endfunction
	endclass

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;
	logic             m_tlast;

	reorder_tracker tracker;
	int send_idle_pct = 36;
	int recv_idle_pct = 47;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	sequence_reorder_buffer #(.WINDOW(WINDOW_DEF)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// transfers on both sides, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) tracker.note_arrival(s_tdata);
		if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata, m_tlast);
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_packet(input logic [15:0] len, input logic [SEQ_W-1:0] seq,
			input logic [PAY_W-1:0] pay);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pay, seq, len};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly traffic around the expected sequence, some drops of each kind
	task automatic send_random_packet();
		int unsigned      pick;
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] seq;
		logic [15:0]      len;
		base = tracker.next_seq;
		pick = $urandom_range(99);
		len  = $urandom_range(65535, HEADER_BYTES);
		if (pick < 8) begin
			len = $urandom_range(HEADER_BYTES - 1, 0);
			seq = $urandom;
		end else if (pick < 16) begin
			seq = (base == 0) ? $urandom : base - $urandom_range((base > 40) ? 40 : base, 1);
		end else if (pick < 20) begin
			seq = $urandom;
		end else if (pick < 26) begin
			seq = base + $urandom_range(WINDOW_DEF + 8, WINDOW_DEF);
		end else if (pick < 55) begin
			seq = base;
		end else begin
			seq = base + $urandom_range(WINDOW_DEF - 1, 1);
		end
		send_packet(len, seq, $urandom_range(65535, 0));
	endtask

	// park every slot but the head in shuffled order, then fill the head: a full-window release
	task automatic send_window_fill();
		int unsigned      order [WINDOW_DEF-1];
		int unsigned      j;
		int unsigned      tmp;
		logic [SEQ_W-1:0] base;
		base = tracker.next_seq;
		for (int i = 0; i < WINDOW_DEF - 1; i++) order[i] = i + 1;
		for (int i = WINDOW_DEF - 2; i > 0; i--) begin
			j        = $urandom_range(i, 0);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < WINDOW_DEF - 1; i++)
			send_packet($urandom_range(65535, HEADER_BYTES), base + order[i],
				$urandom_range(65535, 0));
		send_packet($urandom_range(65535, HEADER_BYTES), base, $urandom_range(65535, 0));
	endtask

	initial begin
		tracker = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: short, stale, overflow edges, reorder, duplicate, release
		send_packet(16'd0,      32'hFFFF_FFFF, 16'hFFFF);
		send_packet(16'd11,     32'd0,         16'd5);
		send_packet(16'd12,     32'd0,         16'd0);
		send_packet(16'hFFFF,   32'd1,         16'hFFFF);
		send_packet(16'd100,    32'd0,         16'd3);
		send_packet(16'd40,     32'd2 + WINDOW_DEF, 16'd1);
		send_packet(16'd40,     32'hFFFF_FFFF, 16'd2);
		send_packet(16'd40,     32'd1 + WINDOW_DEF, 16'hABCD);
		send_packet(16'd40,     32'd4,         16'd7);
		send_packet(16'd40,     32'd4,         16'd9);
		send_packet(16'd40,     32'd3,         16'h5555);
		send_packet(16'd12,     32'd2,         16'h00FF);
		send_packet(16'd40,     32'd1,         16'd0);

		repeat (30) send_random_packet();

		send_idle_pct = 47;
		recv_idle_pct = 36;
		repeat (30) send_random_packet();

		// no idling; receiver holds off at the start of a full-window fill
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_reqs++;
		send_window_fill();
		repeat (15) send_random_packet();
		s_tvalid <= 1'b0;

		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
